FILE: rtl/tss_pkg.sv
// ----------------------------------------------------------------------------
// tss_pkg
// Shared constants, pipeline types and the divider step for the texture span
// segmenter.
// ----------------------------------------------------------------------------
`default_nettype none

package tss_pkg;

    localparam int COORD_BITS       = 12;
    localparam int TEXTURE_DIM_BITS = 10;

    localparam int SPAN_W       = 16;
    localparam int CALC_W       = SPAN_W + 2;
    localparam int TEXCFG_W     = 11;
    localparam int BPP_W        = 6;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_INDEX_W  = 3;
    localparam int TEX_MAX      = 1 << TEXTURE_DIM_BITS;
    localparam int SEG_COUNT    = 3;
    localparam int BITS_PER_BYTE = 8;
    localparam int BYTE_SHIFT   = $clog2(BITS_PER_BYTE);
    localparam int BYTE_W       = TEXTURE_DIM_BITS + 3;

    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES = (COORD_BITS + 1 + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam int DIV_W      = DIV_STAGES * STEPS_PER_STAGE;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CLIP_LEFT      = 3'd0,
        CFG_CLIP_RIGHT     = 3'd1,
        CFG_CLIP_TOP       = 3'd2,
        CFG_CLIP_BOTTOM    = 3'd3,
        CFG_TEXTURE_WIDTH  = 3'd4,
        CFG_TEXTURE_HEIGHT = 3'd5,
        CFG_CANVAS_BPP     = 3'd6,
        CFG_TEXTURE_BPP    = 3'd7
    } cfg_index_t;

    typedef logic [COORD_BITS-1:0]       coord_t;
    typedef logic [COORD_BITS:0]         ext_t;
    typedef logic [TEXTURE_DIM_BITS-1:0] tex_t;
    typedef logic [TEXTURE_DIM_BITS:0]   texdim_t;
    typedef logic signed [CALC_W-1:0]    calc_t;
    typedef logic [DIV_W-1:0]            div_word_t;

    typedef struct packed {
        logic   ok;
        calc_t  x;
        calc_t  hi;
        coord_t row;
    } pre_stage_t;

    typedef struct packed {
        logic   ok;
        coord_t lo;
        ext_t   end_x;
        ext_t   wcl;
        coord_t row;
    } clip_stage_t;

    typedef struct packed {
        tex_t      rem;
        div_word_t dvd;
        div_word_t q;
    } div_lane_t;

    typedef struct packed {
        logic      ok;
        coord_t    lo;
        ext_t      end_x;
        ext_t      wcl;
        coord_t    row;
        div_lane_t lane_x;
        div_lane_t lane_e;
        div_lane_t lane_y;
    } div_stage_t;

    typedef struct packed {
        logic    ok;
        logic    has_head;
        coord_t  lo;
        ext_t    wcl;
        coord_t  row;
        tex_t    ix;
        tex_t    iy;
        texdim_t ww;
        ext_t    cnt;
        coord_t  mid_x;
        coord_t  tail_x;
        tex_t    tail_pc;
    } plan_stage_t;

    typedef struct packed {
        coord_t  dest_x;
        tex_t    src_x;
        texdim_t pc;
        ext_t    rep;
    } seg_t;

    typedef struct packed {
        seg_t [SEG_COUNT-1:0] seg;
        coord_t               row;
        tex_t                 src_row;
    } item_t;

    // Restoring division, a fixed number of quotient bits per call.
    function automatic div_lane_t div_step(div_lane_t a, texdim_t d);
        div_lane_t r;
        texdim_t   sh;
        r = a;
        for (int i = 0; i < STEPS_PER_STAGE; i++)
        begin
            sh    = {r.rem, r.dvd[DIV_W-1]};
            r.dvd = {r.dvd[DIV_W-2:0], 1'b0};
            if (sh >= d)
            begin
                r.rem = tex_t'(sh - d);
                r.q   = {r.q[DIV_W-2:0], 1'b1};
            end
            else
            begin
                r.rem = sh[TEXTURE_DIM_BITS-1:0];
                r.q   = {r.q[DIV_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/texture_span_segmenter_top.sv
// ----------------------------------------------------------------------------
// texture_span_segmenter_top
// Clips a span request to the clip window and splits it into head, repeated
// full texture row and tail copy commands for a tiled texture blitter.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  cfg       cfg_valid/cfg_ready   cfg_index, cfg_data
//  in        in_valid/in_ready     span_x, span_y, span_width
//  out       out_valid/out_ready   dest_x .. byte_count, last
//
// An item passes DIV_STAGES + 6 register stages (13 by default) before its
// first result; the divider depth, two quotient bits per stage, sets this.
// One item enters per cycle unless the pipeline stalls; an item with k results
// holds the emitter until it has sent all k, as a head, body and tail do.
// Reset clears the valid bits and sets config defaults; no flush is needed.
// The pipeline holds while a planned item waits for the emitter to free up.
// ----------------------------------------------------------------------------
`default_nettype none

module texture_span_segmenter_top (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [tss_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [tss_pkg::CFG_DATA_W-1:0]        cfg_data,

    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [tss_pkg::SPAN_W-1:0]     span_x,
    input  logic signed [tss_pkg::SPAN_W-1:0]     span_y,
    input  logic signed [tss_pkg::SPAN_W-1:0]     span_width,

    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [tss_pkg::COORD_BITS-1:0]        dest_x,
    output logic [tss_pkg::COORD_BITS-1:0]        dest_y,
    output logic [tss_pkg::TEXTURE_DIM_BITS-1:0]  src_x,
    output logic [tss_pkg::TEXTURE_DIM_BITS-1:0]  src_y,
    output logic [tss_pkg::TEXTURE_DIM_BITS:0]    pixel_count,
    output logic [tss_pkg::COORD_BITS:0]          repeat_count,
    output logic [tss_pkg::BYTE_W-1:0]            byte_count,
    output logic                                  last
);

    localparam int C  = tss_pkg::COORD_BITS;
    localparam int T  = tss_pkg::TEXTURE_DIM_BITS;
    localparam int DS = tss_pkg::DIV_STAGES;
    localparam int SN = tss_pkg::SEG_COUNT;

    function automatic tss_pkg::texdim_t tex_dim(logic [tss_pkg::TEXCFG_W-1:0] v);
        tss_pkg::texdim_t d;
        if (v == '0)
            d = tss_pkg::texdim_t'(1);
        else if (32'(v) > 32'(tss_pkg::TEX_MAX))
            d = tss_pkg::texdim_t'(tss_pkg::TEX_MAX);
        else
            d = tss_pkg::texdim_t'(v);
        return d;
    endfunction

    tss_pkg::coord_t               clip_left_reg;
    tss_pkg::coord_t               clip_right_reg;
    tss_pkg::coord_t               clip_top_reg;
    tss_pkg::coord_t               clip_bottom_reg;
    logic [tss_pkg::TEXCFG_W-1:0]  texture_width_reg;
    logic [tss_pkg::TEXCFG_W-1:0]  texture_height_reg;
    logic [tss_pkg::BPP_W-1:0]     canvas_bpp_reg;
    logic [tss_pkg::BPP_W-1:0]     texture_bpp_reg;

    tss_pkg::texdim_t tw;
    tss_pkg::texdim_t th;

    logic                          adv;

    logic                          in_vld_reg;
    logic signed [tss_pkg::SPAN_W-1:0] in_x_reg;
    logic signed [tss_pkg::SPAN_W-1:0] in_y_reg;
    logic signed [tss_pkg::SPAN_W-1:0] in_w_reg;

    logic                          pre_vld_reg;
    tss_pkg::pre_stage_t           pre_reg;
    tss_pkg::pre_stage_t           pre_next;

    logic                          clip_vld_reg;
    tss_pkg::clip_stage_t          clip_reg;
    tss_pkg::clip_stage_t          clip_next;

    logic                          div_vld_reg [DS];
    tss_pkg::div_stage_t           div_reg     [DS];
    tss_pkg::div_stage_t           div_in      [DS];
    tss_pkg::div_stage_t           div_next    [DS];

    logic                          plan_vld_reg;
    tss_pkg::plan_stage_t          plan_reg;
    tss_pkg::plan_stage_t          plan_next;

    logic [SN-1:0]                 item_mask_reg;
    logic [SN-1:0]                 item_mask_next;
    tss_pkg::item_t                item_reg;
    tss_pkg::item_t                item_next;

    logic [1:0]                    sel;
    logic [SN-1:0]                 rest;
    tss_pkg::seg_t                 cur;
    logic                          out_load;
    logic                          seg_free;
    logic [T+tss_pkg::BPP_W:0]     prod;

    logic                          out_valid_reg;
    tss_pkg::coord_t               dest_x_reg;
    tss_pkg::coord_t               dest_y_reg;
    tss_pkg::tex_t                 src_x_reg;
    tss_pkg::tex_t                 src_y_reg;
    tss_pkg::texdim_t              pixel_count_reg;
    tss_pkg::ext_t                 repeat_count_reg;
    logic [tss_pkg::BYTE_W-1:0]    byte_count_reg;
    logic                          last_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_left_reg      <= '0;
            clip_right_reg     <= '1;
            clip_top_reg       <= '0;
            clip_bottom_reg    <= '1;
            texture_width_reg  <= tss_pkg::TEXCFG_W'(1);
            texture_height_reg <= tss_pkg::TEXCFG_W'(1);
            canvas_bpp_reg     <= tss_pkg::BPP_W'(16);
            texture_bpp_reg    <= tss_pkg::BPP_W'(16);
        end
        else if (cfg_valid)
        begin
            case (tss_pkg::cfg_index_t'(cfg_index))
                tss_pkg::CFG_CLIP_LEFT:      clip_left_reg      <= cfg_data[C-1:0];
                tss_pkg::CFG_CLIP_RIGHT:     clip_right_reg     <= cfg_data[C-1:0];
                tss_pkg::CFG_CLIP_TOP:       clip_top_reg       <= cfg_data[C-1:0];
                tss_pkg::CFG_CLIP_BOTTOM:    clip_bottom_reg    <= cfg_data[C-1:0];
                tss_pkg::CFG_TEXTURE_WIDTH:
                    texture_width_reg  <= cfg_data[tss_pkg::TEXCFG_W-1:0];
                tss_pkg::CFG_TEXTURE_HEIGHT:
                    texture_height_reg <= cfg_data[tss_pkg::TEXCFG_W-1:0];
                tss_pkg::CFG_CANVAS_BPP:     canvas_bpp_reg  <= cfg_data[tss_pkg::BPP_W-1:0];
                tss_pkg::CFG_TEXTURE_BPP:    texture_bpp_reg <= cfg_data[tss_pkg::BPP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign tw = tex_dim(texture_width_reg);
    assign th = tex_dim(texture_height_reg);

    // Span end, empty and bpp checks and row window.
    always_comb
    begin
        tss_pkg::calc_t x_ext;
        tss_pkg::calc_t y_ext;
        tss_pkg::calc_t w_ext;
        tss_pkg::calc_t top_ext;
        tss_pkg::calc_t bot_ext;
        x_ext   = tss_pkg::CALC_W'(in_x_reg);
        y_ext   = tss_pkg::CALC_W'(in_y_reg);
        w_ext   = tss_pkg::CALC_W'(in_w_reg);
        top_ext = $signed({{(tss_pkg::CALC_W-C){1'b0}}, clip_top_reg});
        bot_ext = $signed({{(tss_pkg::CALC_W-C){1'b0}}, clip_bottom_reg});
        pre_next.x   = x_ext;
        pre_next.hi  = x_ext + w_ext - tss_pkg::calc_t'(1);
        pre_next.row = y_ext[C-1:0];
        pre_next.ok  = (w_ext > tss_pkg::calc_t'(0)) && (canvas_bpp_reg == texture_bpp_reg)
                       && (y_ext >= top_ext) && (y_ext <= bot_ext);
    end

    // Horizontal clip.
    always_comb
    begin
        tss_pkg::calc_t cl_ext;
        tss_pkg::calc_t cr_ext;
        tss_pkg::calc_t lo_c;
        tss_pkg::calc_t hi_c;
        tss_pkg::calc_t end_c;
        tss_pkg::calc_t wcl_c;
        cl_ext = $signed({{(tss_pkg::CALC_W-C){1'b0}}, clip_left_reg});
        cr_ext = $signed({{(tss_pkg::CALC_W-C){1'b0}}, clip_right_reg});
        lo_c   = (pre_reg.x < cl_ext) ? cl_ext : pre_reg.x;
        hi_c   = (pre_reg.hi > cr_ext) ? cr_ext : pre_reg.hi;
        end_c  = hi_c + tss_pkg::calc_t'(1);
        wcl_c  = end_c - lo_c;
        clip_next.ok    = pre_reg.ok && (lo_c <= hi_c);
        clip_next.lo    = lo_c[C-1:0];
        clip_next.end_x = end_c[C:0];
        clip_next.wcl   = wcl_c[C:0];
        clip_next.row   = pre_reg.row;
    end

    // Three dividers in lockstep: start column, end column and row.
    always_comb
    begin
        div_in[0].ok         = clip_reg.ok;
        div_in[0].lo         = clip_reg.lo;
        div_in[0].end_x      = clip_reg.end_x;
        div_in[0].wcl        = clip_reg.wcl;
        div_in[0].row        = clip_reg.row;
        div_in[0].lane_x.rem = '0;
        div_in[0].lane_x.dvd = tss_pkg::DIV_W'(clip_reg.lo);
        div_in[0].lane_x.q   = '0;
        div_in[0].lane_e.rem = '0;
        div_in[0].lane_e.dvd = tss_pkg::DIV_W'(clip_reg.end_x);
        div_in[0].lane_e.q   = '0;
        div_in[0].lane_y.rem = '0;
        div_in[0].lane_y.dvd = tss_pkg::DIV_W'(clip_reg.row);
        div_in[0].lane_y.q   = '0;
        for (int k = 1; k < DS; k++)
            div_in[k] = div_reg[k-1];
        for (int k = 0; k < DS; k++)
        begin
            div_next[k]        = div_in[k];
            div_next[k].lane_x = tss_pkg::div_step(div_in[k].lane_x, tw);
            div_next[k].lane_e = tss_pkg::div_step(div_in[k].lane_e, tw);
            div_next[k].lane_y = tss_pkg::div_step(div_in[k].lane_y, th);
        end
    end

    // Segment geometry from quotients and remainders.
    always_comb
    begin
        tss_pkg::div_word_t q_diff;
        tss_pkg::div_stage_t dl;
        dl = div_reg[DS-1];
        plan_next.ok       = dl.ok;
        plan_next.lo       = dl.lo;
        plan_next.wcl      = dl.wcl;
        plan_next.row      = dl.row;
        plan_next.ix       = dl.lane_x.rem;
        plan_next.iy       = dl.lane_y.rem;
        plan_next.tail_pc  = dl.lane_e.rem;
        plan_next.has_head = (dl.lane_x.rem != '0);
        plan_next.ww       = tw - tss_pkg::texdim_t'(dl.lane_x.rem);
        q_diff             = dl.lane_e.q - dl.lane_x.q
                             - tss_pkg::DIV_W'(plan_next.has_head);
        plan_next.cnt      = q_diff[C:0];
        plan_next.mid_x    = plan_next.has_head
                             ? tss_pkg::coord_t'(dl.lo + tss_pkg::coord_t'(plan_next.ww))
                             : dl.lo;
        plan_next.tail_x   = tss_pkg::coord_t'(dl.end_x - tss_pkg::ext_t'(dl.lane_e.rem));
    end

    // Build the up to three commands of one item.
    always_comb
    begin
        logic fits;
        fits = 32'(plan_reg.ww) >= 32'(plan_reg.wcl);
        item_next.row        = plan_reg.row;
        item_next.src_row    = plan_reg.iy;
        item_next.seg[0].dest_x = plan_reg.lo;
        item_next.seg[0].src_x  = plan_reg.ix;
        item_next.seg[0].pc     = fits ? tss_pkg::texdim_t'(plan_reg.wcl) : plan_reg.ww;
        item_next.seg[0].rep    = tss_pkg::ext_t'(1);
        item_next.seg[1].dest_x = plan_reg.mid_x;
        item_next.seg[1].src_x  = '0;
        item_next.seg[1].pc     = tw;
        item_next.seg[1].rep    = plan_reg.cnt;
        item_next.seg[2].dest_x = plan_reg.tail_x;
        item_next.seg[2].src_x  = '0;
        item_next.seg[2].pc     = tss_pkg::texdim_t'(plan_reg.tail_pc);
        item_next.seg[2].rep    = tss_pkg::ext_t'(1);
        if (!plan_reg.ok)
            item_mask_next = '0;
        else if (fits)
            item_mask_next = SN'(1);
        else
            item_mask_next = {plan_reg.tail_pc != '0, plan_reg.cnt != '0, plan_reg.has_head};
    end

    // Emitter: one command per cycle from the held item, unless the output stalls.
    always_comb
    begin
        if (item_mask_reg[0])
            sel = 2'd0;
        else if (item_mask_reg[1])
            sel = 2'd1;
        else
            sel = 2'd2;
        rest     = item_mask_reg & (item_mask_reg - SN'(1));
        cur      = item_reg.seg[sel];
        out_load = (item_mask_reg != '0) && (!out_valid_reg || out_ready);
        seg_free = (item_mask_reg == '0) || (out_load && (rest == '0));
        adv      = !plan_vld_reg || seg_free;
        prod     = cur.pc * canvas_bpp_reg;
    end

    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg   <= 1'b0;
            pre_vld_reg  <= 1'b0;
            clip_vld_reg <= 1'b0;
            for (int k = 0; k < DS; k++)
                div_vld_reg[k] <= 1'b0;
            plan_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            in_vld_reg     <= in_valid;
            pre_vld_reg    <= in_vld_reg;
            clip_vld_reg   <= pre_vld_reg;
            div_vld_reg[0] <= clip_vld_reg;
            for (int k = 1; k < DS; k++)
                div_vld_reg[k] <= div_vld_reg[k-1];
            plan_vld_reg   <= div_vld_reg[DS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_x_reg <= span_x;
            in_y_reg <= span_y;
            in_w_reg <= span_width;
            pre_reg  <= pre_next;
            clip_reg <= clip_next;
            for (int k = 0; k < DS; k++)
                div_reg[k] <= div_next[k];
            plan_reg <= plan_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_mask_reg <= '0;
        else if (seg_free)
            item_mask_reg <= plan_vld_reg ? item_mask_next : '0;
        else if (out_load)
            item_mask_reg <= rest;
    end

    always_ff @(posedge clk)
    begin
        if (seg_free && plan_vld_reg)
            item_reg <= item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            dest_x_reg       <= cur.dest_x;
            dest_y_reg       <= item_reg.row;
            src_x_reg        <= cur.src_x;
            src_y_reg        <= item_reg.src_row;
            pixel_count_reg  <= cur.pc;
            repeat_count_reg <= cur.rep;
            byte_count_reg   <= prod[tss_pkg::BYTE_SHIFT +: tss_pkg::BYTE_W];
            last_reg         <= (rest == '0);
        end
    end

    assign out_valid    = out_valid_reg;
    assign dest_x       = dest_x_reg;
    assign dest_y       = dest_y_reg;
    assign src_x        = src_x_reg;
    assign src_y        = src_y_reg;
    assign pixel_count  = pixel_count_reg;
    assign repeat_count = repeat_count_reg;
    assign byte_count   = byte_count_reg;
    assign last         = last_reg;

    a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid)
        else $error("a non-final command was not followed by another");

    a_item_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> item_mask_reg != '0)
        else $error("emitter lost the remaining commands of an item");

    a_plan_holds: assert property (@(posedge clk) disable iff (!rst_n)
        plan_vld_reg && !in_ready |=> plan_vld_reg && $stable(plan_reg))
        else $error("pipeline moved during a stall");

    a_nonzero_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pixel_count != '0) && (repeat_count != '0))
        else $error("command with no pixels or no repetitions");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for texture_span_segmenter_top. A directed table and
// random configuration phases drive span requests. A local copy-plan model
// predicts the head, body and tail copy commands of each span, and each
// command that leaves the block is compared field by field. Both channels
// idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

    import tss_pkg::*;

    localparam int SETTLE_CYCLES  = 30;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int N_PHASES       = 8;
    localparam int PHASE_SPANS    = 55;
    localparam int DIRECTED_ROWS  = 44;

    typedef struct packed {
        logic [COORD_BITS-1:0]       dest_x;
        logic [COORD_BITS-1:0]       dest_y;
        logic [TEXTURE_DIM_BITS-1:0] src_x;
        logic [TEXTURE_DIM_BITS-1:0] src_y;
        logic [TEXTURE_DIM_BITS:0]   pixel_count;
        logic [COORD_BITS:0]         repeat_count;
        logic [BYTE_W-1:0]           byte_count;
        logic                        last;
    } copy_cmd_t;

    typedef enum {ROW_SET, ROW_NONE, ROW_ONE, ROW_PREDICT} row_kind_e;

    typedef struct {
        row_kind_e         kind;
        cfg_index_t        sel;
        int                value;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] w;
        copy_cmd_t         copy;
    } span_row_t;

    localparam copy_cmd_t NO_COPY = '0;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic signed [SPAN_W-1:0] span_x;
    logic signed [SPAN_W-1:0] span_y;
    logic signed [SPAN_W-1:0] span_width;
    logic out_valid;
    logic out_ready;
    logic [COORD_BITS-1:0] dest_x;
    logic [COORD_BITS-1:0] dest_y;
    logic [TEXTURE_DIM_BITS-1:0] src_x;
    logic [TEXTURE_DIM_BITS-1:0] src_y;
    logic [TEXTURE_DIM_BITS:0] pixel_count;
    logic [COORD_BITS:0] repeat_count;
    logic [BYTE_W-1:0] byte_count;
    logic last;

    int clip_left_r;
    int clip_right_r;
    int clip_top_r;
    int clip_bottom_r;
    int texture_width_r;
    int texture_height_r;
    int canvas_bpp_r;
    int texture_bpp_r;

    copy_cmd_t pending_copies[$];
    copy_cmd_t oldest_copy;
    int mismatch_count = 0;
    int quiet_cycles = 0;
    int stall_left = 0;
    bit calm_in;
    bit calm_out;

    span_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_ONE, CFG_CLIP_LEFT, 0, 5, 7, 10,
          '{12'd5, 12'd7, 10'd0, 10'd0, 11'd1, 13'd10, 13'd2, 1'b1}},
        '{ROW_NONE, CFG_CLIP_LEFT, 0, 5, 7, 0, NO_COPY},
        '{ROW_NONE, CFG_CLIP_LEFT, 0, 5, 7, -32768, NO_COPY},
        '{ROW_NONE, CFG_CLIP_LEFT, 0, 5, -1, 10, NO_COPY},
        '{ROW_NONE, CFG_CLIP_LEFT, 0, -32768, 0, 32767, NO_COPY},
        '{ROW_ONE, CFG_CLIP_LEFT, 0, 4095, 4095, 32767,
          '{12'd4095, 12'd4095, 10'd0, 10'd0, 11'd1, 13'd1, 13'd2, 1'b1}},
        '{ROW_NONE, CFG_CLIP_LEFT, 0, 32767, 0, 32767, NO_COPY},
        '{ROW_ONE, CFG_CLIP_LEFT, 0, -100, 4095, 32767,
          '{12'd0, 12'd4095, 10'd0, 10'd0, 11'd1, 13'd4096, 13'd2, 1'b1}},
        '{ROW_NONE, CFG_CLIP_LEFT, 0, 0, 32767, 1, NO_COPY},
        '{ROW_NONE, CFG_CLIP_LEFT, 0, 0, -32768, 1, NO_COPY},
        '{ROW_SET, CFG_TEXTURE_WIDTH, 100, 0, 0, 0, NO_COPY},
        '{ROW_SET, CFG_TEXTURE_HEIGHT, 30, 0, 0, 0, NO_COPY},
        '{ROW_SET, CFG_CLIP_LEFT, 10, 0, 0, 0, NO_COPY},
        '{ROW_SET, CFG_CLIP_RIGHT, 1000, 0, 0, 0, NO_COPY},
        '{ROW_SET, CFG_CLIP_TOP, 5, 0, 0, 0, NO_COPY},
        '{ROW_SET, CFG_CLIP_BOTTOM, 2000, 0, 0, 0, NO_COPY},
        '{ROW_PREDICT, CFG_CLIP_LEFT, 0, 150, 37, 500, NO_COPY},
        '{ROW_PREDICT, CFG_CLIP_LEFT, 0, 120, 38, 20, NO_COPY},
        '{ROW_PREDICT, CFG_CLIP_LEFT, 0, 200, 39, 300, NO_COPY},
        '{ROW_PREDICT, CFG_CLIP_LEFT, 0, 150, 40, 100, NO_COPY},
        '{ROW_PREDICT, CFG_CLIP_LEFT, 0, 200, 41, 150, NO_COPY},
        '{ROW_PREDICT, CFG_CLIP_LEFT, 0, 0, 50, 50, NO_COPY},
        '{ROW_PREDICT, CFG_CLIP_LEFT, 0, 990, 60, 100, NO_COPY},
        '{ROW_NONE, CFG_CLIP_LEFT, 0, 100, 4, 10, NO_COPY},
        '{ROW_NONE, CFG_CLIP_LEFT, 0, 100, 2001, 10, NO_COPY},
        '{ROW_SET, CFG_TEXTURE_BPP, 8, 0, 0, 0, NO_COPY},
        '{ROW_NONE, CFG_CLIP_LEFT, 0, 100, 100, 10, NO_COPY},
        '{ROW_SET, CFG_CANVAS_BPP, 8, 0, 0, 0, NO_COPY},
        '{ROW_PREDICT, CFG_CLIP_LEFT, 0, 100, 100, 10, NO_COPY},
        '{ROW_SET, CFG_TEXTURE_WIDTH, 0, 0, 0, 0, NO_COPY},
        '{ROW_SET, CFG_TEXTURE_HEIGHT, 2047, 0, 0, 0, NO_COPY},
        '{ROW_PREDICT, CFG_CLIP_LEFT, 0, 300, 1500, 40, NO_COPY},
        '{ROW_SET, CFG_TEXTURE_WIDTH, 2047, 0, 0, 0, NO_COPY},
        '{ROW_SET, CFG_CLIP_RIGHT, 4095, 0, 0, 0, NO_COPY},
        '{ROW_PREDICT, CFG_CLIP_LEFT, 0, 1000, 1100, 2500, NO_COPY},
        '{ROW_SET, CFG_CANVAS_BPP, 63, 0, 0, 0, NO_COPY},
        '{ROW_SET, CFG_TEXTURE_BPP, 63, 0, 0, 0, NO_COPY},
        '{ROW_PREDICT, CFG_CLIP_LEFT, 0, 17, 200, 13, NO_COPY},
        '{ROW_SET, CFG_CANVAS_BPP, 0, 0, 0, 0, NO_COPY},
        '{ROW_SET, CFG_TEXTURE_BPP, 0, 0, 0, 0, NO_COPY},
        '{ROW_PREDICT, CFG_CLIP_LEFT, 0, 5, 200, 3, NO_COPY},
        '{ROW_SET, CFG_CLIP_LEFT, 3000, 0, 0, 0, NO_COPY},
        '{ROW_SET, CFG_CLIP_RIGHT, 2000, 0, 0, 0, NO_COPY},
        '{ROW_NONE, CFG_CLIP_LEFT, 0, 2500, 200, 100, NO_COPY}
    };

    texture_span_segmenter_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .span_x       (span_x),
        .span_y       (span_y),
        .span_width   (span_width),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .dest_x       (dest_x),
        .dest_y       (dest_y),
        .src_x        (src_x),
        .src_y        (src_y),
        .pixel_count  (pixel_count),
        .repeat_count (repeat_count),
        .byte_count   (byte_count),
        .last         (last)
    );

    function automatic int pick_gap(input bit calm);
        int r;
        if (calm)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic int wrap_period(input int v);
        if (v < 1)
        begin
            return 1;
        end
        return (v > TEX_MAX) ? TEX_MAX : v;
    endfunction

    function automatic copy_cmd_t make_copy(input int dx, input int dy, input int sx,
                                            input int sy, input int pc, input int rep);
        copy_cmd_t c;
        c.dest_x       = COORD_BITS'(dx);
        c.dest_y       = COORD_BITS'(dy);
        c.src_x        = TEXTURE_DIM_BITS'(sx);
        c.src_y        = TEXTURE_DIM_BITS'(sy);
        c.pixel_count  = (TEXTURE_DIM_BITS + 1)'(pc);
        c.repeat_count = (COORD_BITS + 1)'(rep);
        c.byte_count   = BYTE_W'((pc * canvas_bpp_r) / BITS_PER_BYTE);
        c.last         = 1'b0;
        return c;
    endfunction

    // Clips the span and splits it into head, repeated body and tail copies.
    function automatic void plan_copies(input logic signed [15:0] sx,
                                        input logic signed [15:0] sy,
                                        input logic signed [15:0] sw);
        copy_cmd_t segs [3];
        int n;
        int x;
        int y;
        int w;
        int lo;
        int hi;
        int tw;
        int ix;
        int iy;
        int ww;
        int cnt;
        n = 0;
        x = sx;
        y = sy;
        w = sw;
        if (w <= 0 || canvas_bpp_r != texture_bpp_r)
        begin
            return;
        end
        if (y < clip_top_r || y > clip_bottom_r)
        begin
            return;
        end
        lo = (x < clip_left_r) ? clip_left_r : x;
        hi = x + w - 1;
        if (hi > clip_right_r)
        begin
            hi = clip_right_r;
        end
        if (lo > hi)
        begin
            return;
        end
        x = lo;
        w = hi - lo + 1;
        tw = wrap_period(texture_width_r);
        ix = x % tw;
        iy = y % wrap_period(texture_height_r);
        ww = tw - ix;
        if (ww >= w)
        begin
            segs[n] = make_copy(x, y, ix, iy, w, 1);
            n++;
        end
        else
        begin
            if (ix > 0)
            begin
                segs[n] = make_copy(x, y, ix, iy, ww, 1);
                n++;
                w -= ww;
                x += ww;
            end
            cnt = w / tw;
            if (cnt > 0)
            begin
                segs[n] = make_copy(x, y, 0, iy, tw, cnt);
                n++;
                x += cnt * tw;
                w -= cnt * tw;
            end
            if (w > 0)
            begin
                segs[n] = make_copy(x, y, 0, iy, w, 1);
                n++;
            end
        end
        segs[n - 1].last = 1'b1;
        for (int i = 0; i < n; i++)
        begin
            pending_copies.push_back(segs[i]);
        end
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic write_reg(input cfg_index_t sel, input int value);
        int mask;
        logic [CFG_DATA_W-1:0] word;
        case (sel)
            CFG_TEXTURE_WIDTH, CFG_TEXTURE_HEIGHT: mask = 'h7FF;
            CFG_CANVAS_BPP, CFG_TEXTURE_BPP:       mask = 'h3F;
            default:                               mask = 'hFFF;
        endcase
        word = CFG_DATA_W'((int'($urandom) & ~mask) | (value & mask));
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= word;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (sel)
            CFG_CLIP_LEFT:      clip_left_r      = word & mask;
            CFG_CLIP_RIGHT:     clip_right_r     = word & mask;
            CFG_CLIP_TOP:       clip_top_r       = word & mask;
            CFG_CLIP_BOTTOM:    clip_bottom_r    = word & mask;
            CFG_TEXTURE_WIDTH:  texture_width_r  = word & mask;
            CFG_TEXTURE_HEIGHT: texture_height_r = word & mask;
            CFG_CANVAS_BPP:     canvas_bpp_r     = word & mask;
            default:            texture_bpp_r    = word & mask;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_span(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic signed [15:0] w);
        int gap;
        gap = pick_gap(calm_in);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        span_x     <= x;
        span_y     <= y;
        span_width <= w;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic release_span();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_copies.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure_phase(input int p);
        int cl;
        int cr;
        int ct;
        int cb;
        int tw;
        int th;
        int cbpp;
        int tbpp;
        int r;
        if (p == 0)
        begin
            cl = 0; cr = 4095; ct = 0; cb = 4095;
            tw = 1; th = 1; cbpp = 1; tbpp = 1;
        end
        else if (p == N_PHASES - 1)
        begin
            cl = 0; cr = 4095; ct = 4095; cb = 4095;
            tw = 1024; th = 1024; cbpp = 32; tbpp = 32;
        end
        else
        begin
            cl = $urandom_range(0, 1500);
            cr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                             : $urandom_range(cl, 4095);
            ct = $urandom_range(0, 2000);
            cb = $urandom_range(ct, 4095);
            r  = $urandom_range(0, 99);
            tw = (r < 10) ? 0 : (r < 20) ? $urandom_range(1025, 2047) :
                 (r < 50) ? $urandom_range(1, 16) : $urandom_range(1, 1024);
            r  = $urandom_range(0, 99);
            th = (r < 10) ? 0 : (r < 20) ? $urandom_range(1025, 2047) :
                 (r < 50) ? $urandom_range(1, 16) : $urandom_range(1, 1024);
            cbpp = $urandom_range(1, 32);
            tbpp = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 63) : cbpp;
        end
        write_reg(CFG_CLIP_LEFT, cl);
        write_reg(CFG_CLIP_RIGHT, cr);
        write_reg(CFG_CLIP_TOP, ct);
        write_reg(CFG_CLIP_BOTTOM, cb);
        write_reg(CFG_TEXTURE_WIDTH, tw);
        write_reg(CFG_TEXTURE_HEIGHT, th);
        write_reg(CFG_CANVAS_BPP, cbpp);
        write_reg(CFG_TEXTURE_BPP, tbpp);
    endtask

    task automatic random_span();
        int x;
        int y;
        int w;
        int pick;
        int span_cap;
        pick = $urandom_range(0, 99);
        span_cap = 3 * wrap_period(texture_width_r) + 2;
        if (span_cap > 4200)
        begin
            span_cap = 4200;
        end
        if (pick < 80)
        begin
            y = (clip_top_r <= clip_bottom_r) ? $urandom_range(clip_top_r, clip_bottom_r)
                                              : $urandom_range(0, 4095);
            if (pick < 8)
            begin
                x = -int'($urandom_range(1, 200));
            end
            else
            begin
                x = $urandom_range((clip_left_r > 64) ? clip_left_r - 64 : 0,
                                   (clip_left_r <= clip_right_r) ? clip_right_r : 4095);
            end
            w = $urandom_range(1, span_cap);
        end
        else if (pick < 90)
        begin
            x = $urandom_range(0, 4095);
            y = $urandom_range(0, 4095);
            w = -int'($urandom_range(0, 32768));
        end
        else
        begin
            x = $urandom_range(0, 65535);
            y = $urandom_range(0, 65535);
            w = $urandom_range(0, 65535);
        end
        send_span(x, y, w);
        plan_copies(x, y, w);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        calm_in  = 1'b0;
        calm_out = 1'b0;
        forever
        begin
            repeat ($urandom_range(100, 400)) @(posedge clk);
            calm_in  = ($urandom_range(0, 3) == 0);
            calm_out = ($urandom_range(0, 3) == 0);
        end
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                stall_left = pick_gap(calm_out);
                out_ready <= (stall_left == 0);
                if (stall_left > 0)
                begin
                    stall_left--;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_copies.size() == 0)
            begin
                $error("copy command with none expected: dest_x %0d dest_y %0d", dest_x, dest_y);
                mismatch_count++;
            end
            else
            begin
                oldest_copy = pending_copies.pop_front();
                check_field("dest_x", oldest_copy.dest_x, dest_x);
                check_field("dest_y", oldest_copy.dest_y, dest_y);
                check_field("src_x", oldest_copy.src_x, src_x);
                check_field("src_y", oldest_copy.src_y, src_y);
                check_field("pixel_count", oldest_copy.pixel_count, pixel_count);
                check_field("repeat_count", oldest_copy.repeat_count, repeat_count);
                check_field("byte_count", oldest_copy.byte_count, byte_count);
                check_field("last", oldest_copy.last, last);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_CLIP_LEFT;
        cfg_data   = '0;
        in_valid   = 1'b0;
        span_x     = '0;
        span_y     = '0;
        span_width = '0;
        clip_left_r      = 0;
        clip_right_r     = 4095;
        clip_top_r       = 0;
        clip_bottom_r    = 4095;
        texture_width_r  = 1;
        texture_height_r = 1;
        canvas_bpp_r     = 16;
        texture_bpp_r    = 16;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_SET)
            begin
                release_span();
                wait_drained();
                write_reg(directed_rows[i].sel, directed_rows[i].value);
            end
            else
            begin
                send_span(directed_rows[i].x, directed_rows[i].y, directed_rows[i].w);
                if (directed_rows[i].kind == ROW_ONE)
                begin
                    pending_copies.push_back(directed_rows[i].copy);
                end
                else if (directed_rows[i].kind == ROW_PREDICT)
                begin
                    plan_copies(directed_rows[i].x, directed_rows[i].y, directed_rows[i].w);
                end
            end
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            release_span();
            wait_drained();
            configure_phase(p);
            for (int k = 0; k < PHASE_SPANS; k++)
            begin
                if ($urandom_range(0, 99) == 0)
                begin
                    release_span();
                    wait_drained();
                end
                random_span();
            end
        end

        release_span();
        wait_drained();
        if (mismatch_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
